// ----- src/ptd_pkg.sv -----
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types and constants of the periodic task dispatcher.
// ----------------------------------------------------------------------------
package ptd_pkg;

   localparam int MAX_TASKS = 16;
   localparam int ID_W      = $clog2(MAX_TASKS);
   localparam int CNT_W     = $clog2(MAX_TASKS + 1);
   localparam int SHARE_SCALE = 1000;

   typedef enum logic [2:0] {
      OP_TICK     = 3'd0,
      OP_REGISTER = 3'd1,
      OP_ENABLE   = 3'd2,
      OP_ELAPSED  = 3'd3,
      OP_USAGE    = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      KIND_DUE      = 3'd0,
      KIND_REG_OK   = 3'd1,
      KIND_REG_REJ  = 3'd2,
      KIND_EN_DONE  = 3'd3,
      KIND_EL_DONE  = 3'd4,
      KIND_USAGE    = 3'd5,
      KIND_NONE_DUE = 3'd6
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   // divider control between sequencer and divider
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;

endpackage

// ----- src/periodic_task_dispatcher.sv -----
// ----------------------------------------------------------------------------
// periodic_task_dispatcher
// Table of periodic tasks: register, enable, run-time accounting, tick scan, usage share.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low. Each result beat is
// shown for one cycle with rsp_valid; last marks the final beat of an item.
// The receiver cannot stall.
// Register, enable and elapsed items: one result beat, registered from the
// DONE state, which is the only state in which these items keep busy high.
// Tick: ST_SCAN steps through the registered tasks (it is entered also with
// an empty table), then ST_DONE follows; each due task is held and goes out
// as a due beat once a later due task is found; the final beat, from ST_DONE,
// carries last and names the last due task, or is a none-due beat.
// Usage: the product with 1000 is formed in ST_MUL, then the bit-serial
// divider forms the share in ST_DIV; the beat is registered from its done.
// A new beat can be taken in the cycle that shows the final result beat.
// Unknown ops are taken and give no result.
// Reset clears all tables and totals at once (flip-flops), no sweep.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [2:0]                 req_op,
   input  logic [31:0]                req_now_ms,
   input  logic [3:0]                 req_task_id,
   input  logic [31:0]                req_interval_ms,
   input  logic                       req_handler_present,
   input  logic                       req_enable_flag,
   input  logic [31:0]                req_elapsed_us,
   output logic                       rsp_valid,
   output logic [2:0]                 rsp_kind,
   output logic [3:0]                 rsp_result_task,
   output logic [63:0]                rsp_task_run_us,
   output logic [63:0]                rsp_sum_run_us,
   output logic [9:0]                 rsp_share_tenths,
   output logic                       rsp_task_enabled,
   output logic [31:0]                rsp_task_interval,
   output logic                       rsp_last
);

   localparam int ID_W  = ptd_pkg::ID_W;
   localparam int CNT_W = ptd_pkg::CNT_W;

   logic [31:0] ivl_ff [ptd_pkg::MAX_TASKS];
   logic [31:0] lrun_ff[ptd_pkg::MAX_TASKS];
   logic [ptd_pkg::MAX_TASKS-1:0] en_ff;
   logic [63:0] tot_ff [ptd_pkg::MAX_TASKS];
   logic [63:0] grand_ff;
   logic [CNT_W-1:0] count_ff;

   ptd_pkg::state_type state_ff, state_in;
   logic [2:0]  op_ff;
   logic [31:0] now_ff;
   logic [3:0]  id_ff;
   logic [31:0] ivlr_ff;
   logic        hnd_ff, enf_ff;
   logic [31:0] el_ff;
   logic [CNT_W-1:0] idx_ff;
   logic        any_ff;
   logic [3:0]  due_id_ff;
   logic [1:0]  mstep_ff;
   logic [63:0] t_ff;
   logic [63:0] g_ff;
   logic [127:0] prod_ff;

   logic        v_ff, v_in;
   logic [2:0]  k_ff, k_in;
   logic [3:0]  rt_ff, rt_in;
   logic [63:0] rtot_ff, rtot_in;
   logic [63:0] rgr_ff, rgr_in;
   logic [9:0]  sh_ff, sh_in;
   logic        ren_ff, ren_in;
   logic [31:0] rivl_ff, rivl_in;
   logic        last_ff, last_in;

   logic        id_ok, id_reg;
   logic [ID_W-1:0] id_idx, scan_idx;
   logic [31:0] elapsed;
   logic        due;
   logic        scan_end;
   logic        reg_rej;
   logic        div_start;
   logic [63:0] quot;
   ptd_pkg::div_ctl_type div_st;

   assign id_ok   = ({1'b0, id_ff} < 5'(ptd_pkg::MAX_TASKS));
   assign id_reg  = id_ok && ({{(CNT_W > 4 ? CNT_W-4 : 0){1'b0}}, id_ff} < count_ff);
   assign id_idx  = id_ff[ID_W-1:0];
   assign scan_idx = idx_ff[ID_W-1:0];
   assign elapsed = now_ff - lrun_ff[scan_idx];
   assign due     = en_ff[scan_idx] && (elapsed >= ivl_ff[scan_idx]);
   assign scan_end = (idx_ff + CNT_W'(1)) >= count_ff;
   assign reg_rej = (count_ff >= CNT_W'(ptd_pkg::MAX_TASKS)) || !hnd_ff;
   assign div_start = (state_ff == ptd_pkg::ST_MUL) && (mstep_ff == 2'd2);

   ptd_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(prod_ff), .divisor(g_ff), .status(div_st), .quotient(quot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptd_pkg::ST_IDLE: begin
            if (start) begin
               if (req_op == ptd_pkg::OP_TICK) state_in = ptd_pkg::ST_SCAN;
               else if (req_op == ptd_pkg::OP_USAGE) state_in = ptd_pkg::ST_MUL;
               else if (req_op <= ptd_pkg::OP_USAGE) state_in = ptd_pkg::ST_DONE;
            end
         end
         ptd_pkg::ST_SCAN: begin
            if (count_ff == '0 || scan_end) state_in = ptd_pkg::ST_DONE;
         end
         ptd_pkg::ST_MUL: begin
            if (mstep_ff == 2'd2) state_in = ptd_pkg::ST_DIV;
         end
         ptd_pkg::ST_DIV: begin
            if (div_st.done) state_in = ptd_pkg::ST_IDLE;
         end
         ptd_pkg::ST_DONE: state_in = ptd_pkg::ST_IDLE;
         default: state_in = ptd_pkg::ST_IDLE;
      endcase
   end

   // result beat
   always_comb begin
      v_in    = 1'b0;
      k_in    = '0;
      rt_in   = '0;
      rtot_in = '0;
      rgr_in  = '0;
      sh_in   = '0;
      ren_in  = 1'b0;
      rivl_in = '0;
      last_in = 1'b0;
      case (state_ff)
         ptd_pkg::ST_SCAN: begin
            // a held due beat goes out once a later one is found
            if (count_ff != '0 && due && any_ff) begin
               v_in  = 1'b1;
               k_in  = ptd_pkg::KIND_DUE;
               rt_in = due_id_ff;
            end
         end
         ptd_pkg::ST_DIV: begin
            if (div_st.done) begin
               v_in    = 1'b1;
               last_in = 1'b1;
               k_in    = ptd_pkg::KIND_USAGE;
               rt_in   = id_ff;
               rtot_in = t_ff;
               rgr_in  = grand_ff;
               ren_in  = id_ok ? en_ff[id_idx] : 1'b0;
               rivl_in = id_ok ? ivl_ff[id_idx] : 32'd0;
               sh_in   = (t_ff > g_ff || quot > 64'(ptd_pkg::SHARE_SCALE)) ?
                         10'(ptd_pkg::SHARE_SCALE) : quot[9:0];
            end
         end
         ptd_pkg::ST_DONE: begin
            case (op_ff)
               ptd_pkg::OP_TICK: begin
                  v_in    = 1'b1;
                  last_in = 1'b1;
                  if (any_ff) begin
                     k_in  = ptd_pkg::KIND_DUE;
                     rt_in = due_id_ff;
                  end else begin
                     k_in  = ptd_pkg::KIND_NONE_DUE;
                  end
               end
               ptd_pkg::OP_REGISTER: begin
                  v_in    = 1'b1;
                  last_in = 1'b1;
                  if (reg_rej) begin
                     k_in  = ptd_pkg::KIND_REG_REJ;
                  end else begin
                     k_in  = ptd_pkg::KIND_REG_OK;
                     rt_in = 4'(count_ff);
                  end
               end
               ptd_pkg::OP_ENABLE: begin
                  v_in    = 1'b1;
                  last_in = 1'b1;
                  k_in    = ptd_pkg::KIND_EN_DONE;
                  rt_in   = id_ff;
               end
               ptd_pkg::OP_ELAPSED: begin
                  v_in    = 1'b1;
                  last_in = 1'b1;
                  k_in    = ptd_pkg::KIND_EL_DONE;
                  rt_in   = id_ff;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // outputs
   assign busy = (state_ff != ptd_pkg::ST_IDLE);
   assign rsp_valid          = v_ff;
   assign rsp_kind           = k_ff;
   assign rsp_result_task    = rt_ff;
   assign rsp_task_run_us    = rtot_ff;
   assign rsp_sum_run_us     = rgr_ff;
   assign rsp_share_tenths   = sh_ff;
   assign rsp_task_enabled   = ren_ff;
   assign rsp_task_interval  = rivl_ff;
   assign rsp_last           = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptd_pkg::ST_IDLE;
         v_ff     <= 1'b0;
         count_ff <= '0;
         grand_ff <= '0;
         en_ff    <= '0;
         for (int i = 0; i < ptd_pkg::MAX_TASKS; i++) begin
            ivl_ff[i]  <= '0;
            lrun_ff[i] <= '0;
            tot_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         v_ff     <= v_in;
         k_ff     <= k_in;
         rt_ff    <= rt_in;
         rtot_ff  <= rtot_in;
         rgr_ff   <= rgr_in;
         sh_ff    <= sh_in;
         ren_ff   <= ren_in;
         rivl_ff  <= rivl_in;
         last_ff  <= last_in;
         case (state_ff)
            ptd_pkg::ST_IDLE: begin
               if (start) begin
                  op_ff    <= req_op;
                  now_ff   <= req_now_ms;
                  id_ff    <= req_task_id;
                  ivlr_ff  <= req_interval_ms;
                  hnd_ff   <= req_handler_present;
                  enf_ff   <= req_enable_flag;
                  el_ff    <= req_elapsed_us;
                  idx_ff   <= '0;
                  any_ff   <= 1'b0;
                  mstep_ff <= '0;
                  prod_ff  <= '0;
               end
            end
            ptd_pkg::ST_SCAN: begin
               if (count_ff != '0) begin
                  if (due) begin
                     lrun_ff[scan_idx] <= now_ff;
                     due_id_ff <= 4'(idx_ff);
                     any_ff    <= 1'b1;
                  end
                  idx_ff <= idx_ff + CNT_W'(1);
               end
            end
            ptd_pkg::ST_MUL: begin
               case (mstep_ff)
                  2'd0: begin
                     t_ff <= id_ok ? tot_ff[id_idx] : 64'd0;
                     g_ff <= (grand_ff == '0) ? 64'd1 : grand_ff;
                  end
                  2'd1: begin
                     // t*1000 = t*1024 - t*16 - t*8
                     prod_ff <= {54'd0, t_ff, 10'd0} - {60'd0, t_ff, 4'd0}
                              - {61'd0, t_ff, 3'd0};
                  end
                  default: ;
               endcase
               mstep_ff <= mstep_ff + 2'd1;
            end
            ptd_pkg::ST_DONE: begin
               case (op_ff)
                  ptd_pkg::OP_REGISTER: begin
                     if (!reg_rej) begin
                        ivl_ff[count_ff[ID_W-1:0]]  <= (ivlr_ff == '0) ? 32'd1 : ivlr_ff;
                        lrun_ff[count_ff[ID_W-1:0]] <= '0;
                        en_ff[count_ff[ID_W-1:0]]   <= 1'b1;
                        count_ff <= count_ff + CNT_W'(1);
                     end
                  end
                  ptd_pkg::OP_ENABLE: begin
                     if (id_reg) en_ff[id_idx] <= enf_ff;
                  end
                  ptd_pkg::OP_ELAPSED: begin
                     if (id_reg) begin
                        tot_ff[id_idx] <= tot_ff[id_idx] + {32'd0, el_ff};
                        grand_ff <= grand_ff + {32'd0, el_ff};
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

endmodule

// ----- src/ptd_divider.sv -----
// ----------------------------------------------------------------------------
// ptd_divider
// Restoring divider, 128-bit dividend by 64-bit divisor, one quotient bit
// per cycle; keeps the low 64 quotient bits.
// ----------------------------------------------------------------------------
module ptd_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [127:0]           dividend,
   input  logic [63:0]            divisor,
   output ptd_pkg::div_ctl_type   status,
   output logic [63:0]            quotient
);

   logic [127:0] num_ff, num_in;
   logic [63:0]  rem_ff, rem_in;
   logic [63:0]  q_ff, q_in;
   logic [63:0]  den_ff, den_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [64:0]  shifted;
   logic [64:0]  diff;

   always_comb begin
      shifted = {rem_ff, num_ff[127]};
      diff    = shifted - {1'b0, den_ff};
      num_in  = num_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[126:0], 1'b0};
         if (!diff[64]) begin
            rem_in = diff[63:0];
            q_in   = {q_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted[63:0];
            q_in   = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd127) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.start = start;
   assign status.busy  = busy_ff;
   assign status.done  = done_ff;
   assign quotient     = q_ff;

endmodule

// ----- src/ptd_checker.sv -----
// ----------------------------------------------------------------------------
// ptd_checker
// Port-level checks of the periodic task dispatcher.
// ----------------------------------------------------------------------------
module ptd_port_checks (
   input logic       clock,
   input logic       reset,
   input logic       busy,
   input logic       rsp_valid,
   input logic [2:0] rsp_kind,
   input logic       rsp_last,
   input logic [9:0] rsp_share_tenths
);

   a_share_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_share_tenths <= 10'd1000)
      else $error("share beyond full");

   a_none_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == ptd_pkg::KIND_NONE_DUE |-> rsp_last)
      else $error("none-due beat not last");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != ptd_pkg::KIND_DUE |-> rsp_last)
      else $error("single beat not last");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy && !$past(busy) |-> !rsp_valid)
      else $error("beat while idle");

endmodule

bind periodic_task_dispatcher ptd_port_checks u_ptd_port_checks (
   .clock(clock), .reset(reset), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_kind(rsp_kind), .rsp_last(rsp_last),
   .rsp_share_tenths(rsp_share_tenths)
);
